>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define B85_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define B85_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/b85_pkg.sv
// shared types, constants and helpers of the base-85 text encoder
package b85_pkg;

  // character codes
  localparam logic [7:0] CHAR_BIAS = 8'd33;
  localparam logic [7:0] NEWLINE   = 8'd10;

  // digit layout
  localparam int unsigned RADIX     = 85;
  localparam int unsigned DIGITS    = 5;
  localparam int unsigned SER_DEPTH = DIGITS + 1;
  localparam int unsigned SER_CNT_W = $clog2(SER_DEPTH + 1);

  // powers of the radix used as divisors
  localparam longint unsigned DIV1 = 64'd85;
  localparam longint unsigned DIV2 = DIV1 * 64'd85;
  localparam longint unsigned DIV3 = DIV2 * 64'd85;
  localparam longint unsigned DIV4 = DIV3 * 64'd85;

  // shift amounts for exact reciprocal division of a 32-bit word
  localparam int unsigned SH1 = 32 + $clog2(DIV1);
  localparam int unsigned SH2 = 32 + $clog2(DIV2);
  localparam int unsigned SH3 = 32 + $clog2(DIV3);
  localparam int unsigned SH4 = 32 + $clog2(DIV4);

  // reciprocals, rounded up
  localparam logic [32:0] RECIP1 = 33'((64'd1 << SH1) / DIV1 + 64'd1);
  localparam logic [32:0] RECIP2 = 33'((64'd1 << SH2) / DIV2 + 64'd1);
  localparam logic [32:0] RECIP3 = 33'((64'd1 << SH3) / DIV3 + 64'd1);
  localparam logic [32:0] RECIP4 = 33'((64'd1 << SH4) / DIV4 + 64'd1);

  // quotient widths for a 32-bit word
  localparam int unsigned Q1_W = 26;
  localparam int unsigned Q2_W = 20;
  localparam int unsigned Q3_W = 13;
  localparam int unsigned Q4_W = 7;

  // product width of word times reciprocal
  localparam int unsigned PROD_W = 65;

  typedef struct packed {
    logic [31:0] word;
    logic        has_digits;
    logic        has_nl;
  } job_t;

  typedef struct packed {
    logic [31:0]     word;
    logic [Q1_W-1:0] q1;
    logic [Q2_W-1:0] q2;
    logic [Q3_W-1:0] q3;
    logic [Q4_W-1:0] q4;
    logic            has_digits;
    logic            has_nl;
  } quot_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  // digit = lo - 85*hi, known to be below 85, so 7 bits are enough
  function automatic logic [7:0] digit_char(input logic [6:0] lo, input logic [6:0] hi);
    logic [6:0] prod;
    logic [6:0] dig;
    prod = 7'(hi * 7'(RADIX));
    dig  = lo - prod;
    return {1'b0, dig} + CHAR_BIAS;
  endfunction

endpackage

>>> sv/b85_stream_ifs.sv
// stream interfaces for input bytes and output characters
interface b85_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface b85_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

>>> sv/b85_group_acc.sv
// byte collector: packs bytes into a group and issues one job per full group or end
module b85_group_acc
  import b85_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  b85_in_if.sink      in_chan,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic [31:0] group_r, group_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        job_valid_r, job_valid_nxt;
  job_t        job_r, job_nxt;
  logic [31:0] shifted;
  logic        in_acc;

  // take a byte whenever the job slot is free or draining
  assign in_chan.ready = !job_valid_r || job_ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign shifted       = {group_r[23:0], in_chan.data_byte};

  // group collection and job creation
  always_comb begin
    group_nxt     = group_r;
    count_nxt     = count_r;
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r && !job_ready;
    if (in_acc) begin
      if (in_chan.end_of_stream) begin
        job_valid_nxt      = 1'b1;
        job_nxt.has_nl     = 1'b1;
        job_nxt.has_digits = (count_r != 2'd0);
        case (count_r)
          2'd1:    job_nxt.word = {group_r[7:0], 24'h0};
          2'd2:    job_nxt.word = {group_r[15:0], 16'h0};
          2'd3:    job_nxt.word = {group_r[23:0], 8'h0};
          default: job_nxt.word = group_r;
        endcase
        group_nxt = '0;
        count_nxt = '0;
      end else if (count_r == 2'd3) begin
        job_valid_nxt      = 1'b1;
        job_nxt.word       = shifted;
        job_nxt.has_digits = 1'b1;
        job_nxt.has_nl     = 1'b0;
        group_nxt          = '0;
        count_nxt          = '0;
      end else begin
        group_nxt = shifted;
        count_nxt = count_r + 2'd1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r     <= '0;
      count_r     <= '0;
      job_valid_r <= 1'b0;
    end else begin
      group_r     <= group_nxt;
      count_r     <= count_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

>>> sv/b85_digit_div.sv
// quotient stage: divides the group by the four radix powers in parallel
module b85_digit_div
  import b85_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  job_valid,
  output logic  job_ready,
  input  job_t  job,
  output logic  q_valid,
  input  logic  q_ready,
  output quot_t quot
);

  logic              q_valid_r;
  quot_t             quot_r, quot_nxt;
  logic [PROD_W-1:0] prod1, prod2, prod3, prod4;

  assign job_ready = !q_valid_r || q_ready;

  // reciprocal multiplies, exact floor for any 32-bit word
  assign prod1 = PROD_W'(job.word) * PROD_W'(RECIP1);
  assign prod2 = PROD_W'(job.word) * PROD_W'(RECIP2);
  assign prod3 = PROD_W'(job.word) * PROD_W'(RECIP3);
  assign prod4 = PROD_W'(job.word) * PROD_W'(RECIP4);

  always_comb begin
    quot_nxt.word       = job.word;
    quot_nxt.q1         = prod1[SH1 +: Q1_W];
    quot_nxt.q2         = prod2[SH2 +: Q2_W];
    quot_nxt.q3         = prod3[SH3 +: Q3_W];
    quot_nxt.q4         = prod4[SH4 +: Q4_W];
    quot_nxt.has_digits = job.has_digits;
    quot_nxt.has_nl     = job.has_nl;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (job_ready) begin
      q_valid_r <= job_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      quot_r <= quot_nxt;
    end
  end

  assign q_valid = q_valid_r;
  assign quot    = quot_r;

endmodule

>>> sv/b85_char_ser.sv
// character stage: forms the digit characters and shifts them out one word a cycle while out_chan.ready is high
module b85_char_ser
  import b85_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  quot_t      quot,
  b85_out_if.source  out_chan
);

  char_t                buf_r [SER_DEPTH];
  char_t                load_buf [SER_DEPTH];
  logic [SER_CNT_W-1:0] cnt_r;
  logic [SER_CNT_W-1:0] load_cnt;
  logic                 load;
  logic                 out_acc;
  char_t                nl_char;
  char_t                dig [DIGITS];

  assign out_acc = out_chan.valid && out_chan.ready;
  assign q_ready = (cnt_r == '0) || ((cnt_r == SER_CNT_W'(1)) && out_chan.ready);
  assign load    = q_valid && q_ready;

  // digits, most significant first
  always_comb begin
    nl_char.ch   = NEWLINE;
    nl_char.last = 1'b1;
    dig[0].ch    = {1'b0, quot.q4} + CHAR_BIAS;
    dig[1].ch    = digit_char(quot.q3[6:0], quot.q4);
    dig[2].ch    = digit_char(quot.q2[6:0], quot.q3[6:0]);
    dig[3].ch    = digit_char(quot.q1[6:0], quot.q2[6:0]);
    dig[4].ch    = digit_char(quot.word[6:0], quot.q1[6:0]);
    for (int i = 0; i < DIGITS; i++) begin
      dig[i].last = 1'b0;
    end
  end

  // load image: five digits, five digits then newline, or newline alone
  always_comb begin
    for (int i = 0; i < SER_DEPTH; i++) begin
      load_buf[i] = nl_char;
    end
    if (quot.has_digits) begin
      for (int i = 0; i < DIGITS; i++) begin
        load_buf[i] = dig[i];
      end
      load_cnt = quot.has_nl ? SER_CNT_W'(SER_DEPTH) : SER_CNT_W'(DIGITS);
    end else begin
      load_cnt = SER_CNT_W'(1);
    end
  end

  // word count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - SER_CNT_W'(1);
    end
  end

  // shift line
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= load_buf;
    end else if (out_acc) begin
      for (int i = 0; i < SER_DEPTH - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  assign out_chan.valid    = (cnt_r != '0);
  assign out_chan.out_char = buf_r[0].ch;
  assign out_chan.last     = buf_r[0].last;

endmodule

>>> sv/base85_text_encoder_top.sv
// top level of the base-85 text encoder
//
//  channel    dir  payload                      handshake
//  in_chan    in   data_byte, end_of_stream     valid / ready
//  out_chan   out  out_char, last               valid / ready
//
//  a byte is taken every cycle while the group job slot is free; one output word per cycle while out_chan.ready is high
//  the first character of a full group or an end word passes the job register, the quotient
//  register and the shift line before it is valid on out_chan
//  five digit words per group (six with the newline) leave at one a cycle from a shift line
//  while out_chan.ready is high, so a steady byte stream is paced by the output shift line
//  rst_n is synchronous and clears the group, the count and all stage valids
//  output stalls back up through the quotient and job registers to in_chan.ready
module base85_text_encoder_top
  import b85_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  b85_in_if.sink     in_chan,
  b85_out_if.source  out_chan
);

  logic  job_valid;
  logic  job_ready;
  job_t  job;
  logic  q_valid;
  logic  q_ready;
  quot_t quot;

  // byte collection
  b85_group_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // radix division
  b85_digit_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .quot      (quot)
  );

  // character output
  b85_char_ser u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .quot     (quot),
    .out_chan (out_chan)
  );

endmodule

>>> sv/b85_checker.sv
// port checker for the base-85 text encoder and its bind
`include "assert_macros.svh"

module b85_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // a pending word is not withdrawn
  `B85_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped while stalled")

  // the last word is the newline
  `B85_ASSERT_SAME(a_last_nl, out_valid && out_last, out_char == 8'd10, "last word is not a newline")

  // digit words lie in the printable digit range
  `B85_ASSERT_SAME(a_digit_rng, out_valid && !out_last, (out_char >= 8'd33) && (out_char <= 8'd117), "digit character out of range")

  // nothing is pending right after reset
  `B85_ASSERT_SAME(a_rst_empty, !$past(rst_n), !out_valid, "output valid right after reset")

endmodule

bind base85_text_encoder_top b85_checker u_b85_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_char  (out_chan.out_char),
  .out_last  (out_chan.last)
);
